// File: rtl/core/hdr2srgb_pkg.sv
package hdr2srgb_pkg;

   localparam int LINEAR_FRACTION_BITS  = 16;
   localparam int GAMMA_TABLE_ADDR_BITS = 10;

   localparam int HALF_W  = 16;
   localparam int CODE_W  = 8;
   localparam int SCALE_W = 24;
   localparam int MANT_W  = 11;
   localparam int PROD_W  = MANT_W + SCALE_W;
   // encoded value in Q0.16, 1.0 included
   localparam int ENC_W   = 17;

   localparam logic [SCALE_W-1:0] SCALE_RESET  = 24'h010000;
   localparam logic [CODE_W-1:0]  ALPHA_OPAQUE = 8'hFF;

   // floor(z / 25) as (z * RECIP25_MUL) >> RECIP25_SHIFT, exact for z below 2^17
   localparam int                 RECIP25_IN_W  = 17;
   localparam int                 RECIP25_W     = 19;
   localparam logic [RECIP25_W-1:0] RECIP25_MUL = 19'd335545;
   localparam int                 RECIP25_SHIFT = 23;
   localparam int                 LIN_QUOT_W    = RECIP25_IN_W + RECIP25_W - RECIP25_SHIFT;

   // 12.92 = 323 / 25
   localparam logic [8:0] LIN_SLOPE_NUM = 9'd323;

   typedef struct packed {
      logic s1_en;
      logic s2_en;
   } dec_ctrl_type;

   typedef struct packed {
      logic s3_en;
      logic s4_en;
      logic s5_en;
      logic s6_en;
   } enc_ctrl_type;

   // one point of the sRGB curve: 1.055 * (i / 2^addr_bits)^(1/2.4) - 0.055 in Q0.16,
   // the root taken exactly as floor 12th root of v^5 in Q0.20
   function automatic logic [ENC_W-1:0] gamma_point(int unsigned idx, int unsigned addr_bits);
      logic [255:0]      rhs;
      logic [255:0]      lhs;
      longint unsigned   lo;
      longint unsigned   hi;
      longint unsigned   mid;
      longint            e20;
      logic [ENC_W-1:0]  result;
      rhs = 256'd1;
      for (int j = 0; j < 5; j++) begin
         rhs = rhs * 256'(idx);
      end
      rhs = rhs << (240 - 5 * addr_bits);
      lo = 0;
      hi = 64'd1 << 20;
      for (int k = 0; k < 22; k++) begin
         if (lo < hi) begin
            mid = (lo + hi + 1) >> 1;
            lhs = 256'd1;
            for (int j = 0; j < 12; j++) begin
               lhs = lhs * 256'(mid);
            end
            if (lhs <= rhs) begin
               lo = mid;
            end else begin
               hi = mid - 1;
            end
         end
      end
      e20 = longint'(lo) * 1055 - (longint'(55) << 20);
      if (e20 < 0) begin
         result = '0;
      end else begin
         result = ENC_W'((e20 + 8000) / 16000);
      end
      return result;
   endfunction

endpackage

// File: rtl/core/hdr2srgb_decode.sv
module hdr2srgb_decode #(
   parameter int LINEAR_FRACTION_BITS = hdr2srgb_pkg::LINEAR_FRACTION_BITS
) (
   input  logic                                   clock,
   input  hdr2srgb_pkg::dec_ctrl_type             ctrl,
   input  logic [hdr2srgb_pkg::SCALE_W-1:0]       scale,
   input  logic [hdr2srgb_pkg::HALF_W-1:0]        half_in,
   output logic [LINEAR_FRACTION_BITS:0]          lin_out
);

   localparam int F      = LINEAR_FRACTION_BITS;
   localparam int LIN_W  = F + 1;
   localparam int PROD_W = hdr2srgb_pkg::PROD_W;
   localparam int WIDE_W = 64;
   localparam int RSHIFT = 40 - F;

   localparam logic [LIN_W-1:0]  LIN_ONE  = {1'b1, {F{1'b0}}};
   localparam logic [WIDE_W-1:0] WIDE_ONE = WIDE_W'(LIN_ONE);

   logic                                  sign_bit;
   logic [4:0]                            exp_bits;
   logic [9:0]                            man_bits;
   logic [hdr2srgb_pkg::MANT_W-1:0]       mant;

   logic [PROD_W-1:0] prod_ff, prod_in;
   logic [4:0]        eshift_ff, eshift_in;
   logic              zero_ff, zero_in;
   logic              one_ff, one_in;

   logic [WIDE_W-1:0] wide_shl;
   logic [WIDE_W-1:0] wide_lin;
   logic [LIN_W-1:0]  lin_ff, lin_in;

   assign sign_bit = half_in[15];
   assign exp_bits = half_in[14:10];
   assign man_bits = half_in[9:0];
   assign mant     = {(exp_bits != 5'd0), man_bits};

   // stage 1: flags and mantissa times scale
   always_comb begin
      prod_in   = PROD_W'(mant) * PROD_W'(scale);
      eshift_in = (exp_bits == 5'd0) ? 5'd0 : exp_bits - 5'd1;
      zero_in   = sign_bit || (exp_bits == 5'd31 && man_bits != 10'd0);
      one_in    = !sign_bit && exp_bits == 5'd31 && man_bits == 10'd0;
   end

   always_ff @(posedge clock) begin
      if (ctrl.s1_en) begin
         prod_ff   <= prod_in;
         eshift_ff <= eshift_in;
         zero_ff   <= zero_in;
         one_ff    <= one_in;
      end
   end

   // stage 2: scale by exponent, truncate, saturate at 1.0
   assign wide_shl = WIDE_W'(prod_ff) << eshift_ff;
   assign wide_lin = wide_shl >> RSHIFT;

   always_comb begin
      if (zero_ff) begin
         lin_in = '0;
      end else if (one_ff || wide_lin > WIDE_ONE) begin
         lin_in = LIN_ONE;
      end else begin
         lin_in = wide_lin[LIN_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.s2_en) begin
         lin_ff <= lin_in;
      end
   end

   assign lin_out = lin_ff;

endmodule

// File: rtl/core/hdr2srgb_gamma_rom.sv
module hdr2srgb_gamma_rom #(
   parameter int GAMMA_TABLE_ADDR_BITS = hdr2srgb_pkg::GAMMA_TABLE_ADDR_BITS
) (
   input  logic                                  clock,
   input  logic                                  rd_en,
   input  logic [GAMMA_TABLE_ADDR_BITS:0]        rd_addr,
   output logic [hdr2srgb_pkg::ENC_W-1:0]        rd_base,
   output logic [hdr2srgb_pkg::ENC_W-1:0]        rd_delta
);

   localparam int A      = GAMMA_TABLE_ADDR_BITS;
   localparam int ENC_W  = hdr2srgb_pkg::ENC_W;
   localparam int POINTS = (1 << A) + 1;

   typedef logic [2*ENC_W-1:0] rom_word_type;
   typedef rom_word_type rom_array_type [POINTS];
   typedef logic [ENC_W-1:0] point_array_type [POINTS];

   // each word holds a point and the rise to the next one (zero if none)
   function automatic rom_array_type build_table();
      point_array_type  pts;
      rom_array_type    tbl;
      logic [ENC_W-1:0] delta;
      for (int i = 0; i < POINTS; i++) begin
         pts[i] = hdr2srgb_pkg::gamma_point(i, A);
      end
      for (int i = 0; i < POINTS; i++) begin
         delta = '0;
         if (i < POINTS - 1) begin
            if (pts[i+1] > pts[i]) begin
               delta = pts[i+1] - pts[i];
            end
         end
         tbl[i] = {pts[i], delta};
      end
      return tbl;
   endfunction

   localparam rom_array_type GAMMA_ROM = build_table();

   rom_word_type rd_word_ff;

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_word_ff <= GAMMA_ROM[rd_addr];
      end
   end

   assign rd_base  = rd_word_ff[2*ENC_W-1:ENC_W];
   assign rd_delta = rd_word_ff[ENC_W-1:0];

endmodule

// File: rtl/core/hdr2srgb_encode.sv
module hdr2srgb_encode #(
   parameter int LINEAR_FRACTION_BITS  = hdr2srgb_pkg::LINEAR_FRACTION_BITS,
   parameter int GAMMA_TABLE_ADDR_BITS = hdr2srgb_pkg::GAMMA_TABLE_ADDR_BITS
) (
   input  logic                                  clock,
   input  hdr2srgb_pkg::enc_ctrl_type            ctrl,
   input  logic [LINEAR_FRACTION_BITS:0]         lin_in,
   output logic [hdr2srgb_pkg::CODE_W-1:0]       code_out
);

   localparam int F      = LINEAR_FRACTION_BITS;
   localparam int A      = GAMMA_TABLE_ADDR_BITS;
   localparam int LIN_W  = F + 1;
   localparam int ENC_W  = hdr2srgb_pkg::ENC_W;
   localparam int FRAC_W = 24 - A;
   localparam int ZIN_W  = hdr2srgb_pkg::RECIP25_IN_W;
   localparam int RCP_W  = hdr2srgb_pkg::RECIP25_W;
   localparam int QFULL_W = ZIN_W + RCP_W;
   localparam int QOUT_W = hdr2srgb_pkg::LIN_QUOT_W;
   localparam int LOW_W  = F - 8;
   localparam int X_W    = LOW_W + 9;
   localparam int XS_W   = F + 17;
   localparam int DF_W   = ENC_W + FRAC_W;
   localparam int CODE_W = hdr2srgb_pkg::CODE_W;
   localparam int SUM_W  = ENC_W + 9;

   localparam longint unsigned KNEE_FULL = (64'd31308 << F) / 64'd10000000;
   localparam logic [LIN_W-1:0] KNEE     = LIN_W'(KNEE_FULL);

   // stage 3 inputs
   logic [24:0]       l24;
   logic [A:0]        rom_addr;
   logic [X_W-1:0]    x_val;
   logic [XS_W-1:0]   x_shl;
   logic [ZIN_W-1:0]  z_in;
   logic              sel_lin_in;
   logic [ENC_W-1:0]  rom_base;
   logic [ENC_W-1:0]  rom_delta;

   logic [ZIN_W-1:0]  z_ff;
   logic [FRAC_W-1:0] frac_ff;
   logic              sel3_ff;

   // stage 4
   logic [QFULL_W-1:0] q_full;
   logic [DF_W-1:0]    df_full;
   logic [QOUT_W-1:0]  q_ff;
   logic [ENC_W-1:0]   dfrac_ff;
   logic [ENC_W-1:0]   base_ff;
   logic               sel4_ff;

   // stage 5 and 6
   logic [ENC_W:0]     interp_sum;
   logic [ENC_W-1:0]   enc_ff, enc_in;
   logic [SUM_W-1:0]   code_sum;
   logic [CODE_W-1:0]  code_ff, code_in;

   assign l24        = 25'(lin_in) << (24 - F);
   assign rom_addr   = l24[24:24-A];
   // below the knee the value fits under 2^(F-8), so only the low bits matter there
   assign x_val      = X_W'(lin_in[LOW_W-1:0]) * X_W'(hdr2srgb_pkg::LIN_SLOPE_NUM);
   assign x_shl      = XS_W'(x_val) << 16;
   assign z_in       = x_shl[F+16:F];
   assign sel_lin_in = (lin_in <= KNEE);

   hdr2srgb_gamma_rom #(
      .GAMMA_TABLE_ADDR_BITS(A)
   ) u_rom (
      .clock    (clock),
      .rd_en    (ctrl.s3_en),
      .rd_addr  (rom_addr),
      .rd_base  (rom_base),
      .rd_delta (rom_delta)
   );

   always_ff @(posedge clock) begin
      if (ctrl.s3_en) begin
         z_ff    <= z_in;
         frac_ff <= l24[FRAC_W-1:0];
         sel3_ff <= sel_lin_in;
      end
   end

   // stage 4: linear segment divides by 25, curve weights the rise
   assign q_full  = QFULL_W'(z_ff) * QFULL_W'(hdr2srgb_pkg::RECIP25_MUL);
   assign df_full = DF_W'(rom_delta) * DF_W'(frac_ff);

   always_ff @(posedge clock) begin
      if (ctrl.s4_en) begin
         q_ff     <= q_full[QFULL_W-1:hdr2srgb_pkg::RECIP25_SHIFT];
         dfrac_ff <= df_full[DF_W-1:FRAC_W];
         base_ff  <= rom_base;
         sel4_ff  <= sel3_ff;
      end
   end

   // stage 5: pick segment, clamp the interpolated sum
   assign interp_sum = (ENC_W+1)'(base_ff) + (ENC_W+1)'(dfrac_ff);

   always_comb begin
      if (sel4_ff) begin
         enc_in = ENC_W'(q_ff);
      end else if (interp_sum[ENC_W]) begin
         enc_in = '1;
      end else begin
         enc_in = interp_sum[ENC_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.s5_en) begin
         enc_ff <= enc_in;
      end
   end

   // stage 6: enc * 255 rounded to 8 bits
   assign code_sum = (SUM_W'(enc_ff) << 8) - SUM_W'(enc_ff) + SUM_W'(32768);

   always_comb begin
      if (code_sum[SUM_W-1:24] != '0) begin
         code_in = '1;
      end else begin
         code_in = code_sum[23:16];
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.s6_en) begin
         code_ff <= code_in;
      end
   end

   assign code_out = code_ff;

endmodule

// File: rtl/core/hdr2srgb_half_to_srgb8_pixel_top_unused.sv
module hdr2srgb_stage_ctrl #(
   parameter int STAGES = 6
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   input  logic              out_ready,
   output logic [STAGES-1:0] stage_en,
   output logic              out_valid
);

   logic [STAGES-1:0] valid_ff, valid_in;

   // a stage moves when it is empty or the one after it moves
   always_comb begin
      stage_en[STAGES-1] = !valid_ff[STAGES-1] || out_ready;
      for (int k = STAGES - 2; k >= 0; k--) begin
         stage_en[k] = !valid_ff[k] || stage_en[k+1];
      end
      for (int k = 0; k < STAGES; k++) begin
         if (stage_en[k]) begin
            valid_in[k] = (k == 0) ? in_valid : valid_ff[(k == 0) ? 0 : k - 1];
         end else begin
            valid_in[k] = valid_ff[k];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   assign out_valid = valid_ff[STAGES-1];

endmodule

// File: rtl/core/hdr_half_to_srgb8_pixel.sv
// HDR half-float to 8-bit sRGB pixel encoder.
//
// req_* carries one pixel per transfer as three binary16 words of linear
// scRGB; rsp_* returns one RGBA8 pixel per transfer, alpha fixed at 255.
// csr_wr_en writes the exposure scale (Q8.16, 80 / paper white nits); write
// it only while the pipe is empty.
//
// Six register stages: decode and mantissa multiply, exponent shift and
// clamp, gamma ROM read, segment multiplies, segment select, code rounding.
// rsp_tvalid rises once the pixel is held in the code rounding stage.
// Throughput is one pixel per cycle while rsp_tready is high; each channel
// has its own gamma ROM port, read once per pixel.
//
// Reset empties the pipe and sets the scale to 1.0. When rsp_tready is low
// the pipe keeps filling until every stage holds a pixel, then req_tready
// drops; bubbles are squeezed out, nothing is dropped or repeated.
module hdr_half_to_srgb8_pixel #(
   parameter int LINEAR_FRACTION_BITS  = hdr2srgb_pkg::LINEAR_FRACTION_BITS,
   parameter int GAMMA_TABLE_ADDR_BITS = hdr2srgb_pkg::GAMMA_TABLE_ADDR_BITS
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [47:0] req_tdata,   // red_half, green_half, blue_half
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // red_code, green_code, blue_code, alpha_code
   input  logic        csr_wr_en,
   input  logic [23:0] csr_wr_data  // exposure_scale
);

   localparam int STAGES = 6;
   localparam int LIN_W  = LINEAR_FRACTION_BITS + 1;
   localparam int HALF_W = hdr2srgb_pkg::HALF_W;
   localparam int CODE_W = hdr2srgb_pkg::CODE_W;

   logic [hdr2srgb_pkg::SCALE_W-1:0] scale_ff, scale_in;
   logic [STAGES-1:0]                stage_en;
   hdr2srgb_pkg::dec_ctrl_type       dec_ctrl;
   hdr2srgb_pkg::enc_ctrl_type       enc_ctrl;

   logic [HALF_W-1:0] half_ch [3];
   logic [LIN_W-1:0]  lin_ch  [3];
   logic [CODE_W-1:0] code_ch [3];

   always_comb begin
      scale_in = scale_ff;
      if (csr_wr_en) begin
         scale_in = csr_wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         scale_ff <= hdr2srgb_pkg::SCALE_RESET;
      end else begin
         scale_ff <= scale_in;
      end
   end

   hdr2srgb_stage_ctrl #(
      .STAGES(STAGES)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_tvalid),
      .out_ready (rsp_tready),
      .stage_en  (stage_en),
      .out_valid (rsp_tvalid)
   );

   assign req_tready     = stage_en[0];
   assign dec_ctrl.s1_en = stage_en[0];
   assign dec_ctrl.s2_en = stage_en[1];
   assign enc_ctrl.s3_en = stage_en[2];
   assign enc_ctrl.s4_en = stage_en[3];
   assign enc_ctrl.s5_en = stage_en[4];
   assign enc_ctrl.s6_en = stage_en[5];

   assign half_ch[0] = req_tdata[15:0];
   assign half_ch[1] = req_tdata[31:16];
   assign half_ch[2] = req_tdata[47:32];

   for (genvar c = 0; c < 3; c++) begin : g_chan
      hdr2srgb_decode #(
         .LINEAR_FRACTION_BITS(LINEAR_FRACTION_BITS)
      ) u_decode (
         .clock   (clock),
         .ctrl    (dec_ctrl),
         .scale   (scale_ff),
         .half_in (half_ch[c]),
         .lin_out (lin_ch[c])
      );

      hdr2srgb_encode #(
         .LINEAR_FRACTION_BITS (LINEAR_FRACTION_BITS),
         .GAMMA_TABLE_ADDR_BITS(GAMMA_TABLE_ADDR_BITS)
      ) u_encode (
         .clock    (clock),
         .ctrl     (enc_ctrl),
         .lin_in   (lin_ch[c]),
         .code_out (code_ch[c])
      );
   end

   assign rsp_tdata = {hdr2srgb_pkg::ALPHA_OPAQUE, code_ch[2], code_ch[1], code_ch[0]};

endmodule
